/* src/tpqm_pkg.sv */
`default_nettype none
package tpqm_pkg;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned GAIN_W  = 24;
    localparam int unsigned LIMIT_W = 31;
    localparam int unsigned MOTOR_W = 31;
    localparam int unsigned MODE_W  = 3;
    localparam int unsigned INDEX_W = 3;

    localparam logic [MODE_W-1:0] MODE_DISARMED = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ARMED    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_WARN     = 3'd2;
    localparam logic [MODE_W-1:0] MODE_FAILSAFE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_ERROR    = 3'd4;

    localparam logic [INDEX_W-1:0] CFG_GAIN_P     = 3'd0;
    localparam logic [INDEX_W-1:0] CFG_GAIN_I     = 3'd1;
    localparam logic [INDEX_W-1:0] CFG_GAIN_D     = 3'd2;
    localparam logic [INDEX_W-1:0] CFG_INT_LIMIT  = 3'd3;
    localparam logic [INDEX_W-1:0] CFG_OUTPUT_MAX = 3'd4;

    localparam logic [GAIN_W-1:0]  RESET_GAIN_P     = 24'd78643;
    localparam logic [GAIN_W-1:0]  RESET_GAIN_I     = 24'd3277;
    localparam logic [GAIN_W-1:0]  RESET_GAIN_D     = 24'd19661;
    localparam logic [LIMIT_W-1:0] RESET_INT_LIMIT  = 31'd6553600;
    localparam logic [MOTOR_W-1:0] RESET_OUTPUT_MAX = 31'd131072000;

    typedef struct packed {
        logic signed [DATA_W-1:0] roll_target;
        logic signed [DATA_W-1:0] pitch_target;
        logic signed [DATA_W-1:0] yaw_target;
        logic signed [DATA_W-1:0] throttle_level;
        logic signed [DATA_W-1:0] roll_attitude;
        logic signed [DATA_W-1:0] pitch_attitude;
        logic signed [DATA_W-1:0] yaw_attitude;
        logic        [MODE_W-1:0] flight_mode;
    } t_in_word;

    typedef struct packed {
        logic [MOTOR_W-1:0] motor_front_left;
        logic [MOTOR_W-1:0] motor_front_right;
        logic [MOTOR_W-1:0] motor_back_left;
        logic [MOTOR_W-1:0] motor_back_right;
    } t_out_word;

    typedef struct packed {
        logic [GAIN_W-1:0]  gain_p;
        logic [GAIN_W-1:0]  gain_i;
        logic [GAIN_W-1:0]  gain_d;
        logic [LIMIT_W-1:0] int_limit;
    } t_pid_cfg;

    function automatic logic signed [DATA_W-1:0] sat_33(input logic signed [DATA_W:0] v);
        logic signed [DATA_W-1:0] r;
        if (v[DATA_W] != v[DATA_W-1]) begin
            r = v[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* src/tpqm_pid_axis.sv */
`default_nettype none
module tpqm_pid_axis import tpqm_pkg::*; (
    input  wire t_pid_cfg                 i_cfg,
    input  wire logic signed [DATA_W-1:0] i_target,
    input  wire logic signed [DATA_W-1:0] i_attitude,
    input  wire logic signed [DATA_W-1:0] i_sum,
    input  wire logic signed [DATA_W-1:0] i_prev,
    output logic signed [DATA_W-1:0]      o_pid,
    output logic signed [DATA_W-1:0]      o_sum_next,
    output logic signed [DATA_W-1:0]      o_err
);

    localparam int unsigned PROD_W  = GAIN_W + 1 + DATA_W;
    localparam int unsigned SHIFT_W = PROD_W - 16;
    localparam int unsigned TOTAL_W = SHIFT_W + 2;

    logic signed [DATA_W-1:0]  err;
    logic signed [DATA_W-1:0]  s;
    logic signed [DATA_W-1:0]  diff;
    logic signed [PROD_W-1:0]  prod_p;
    logic signed [PROD_W-1:0]  prod_i;
    logic signed [PROD_W-1:0]  prod_d;
    logic signed [TOTAL_W-1:0] total;
    logic signed [DATA_W:0]    s_wide;
    logic signed [DATA_W:0]    lim_pos;
    logic signed [DATA_W:0]    lim_neg;

    always_comb begin
        err  = sat_33(33'(i_target) - 33'(i_attitude));
        s    = sat_33(33'(i_sum) + 33'(err));
        diff = sat_33(33'(err) - 33'(i_prev));

        prod_p = $signed({1'b0, i_cfg.gain_p}) * err;
        prod_i = $signed({1'b0, i_cfg.gain_i}) * s;
        prod_d = $signed({1'b0, i_cfg.gain_d}) * diff;

        total = TOTAL_W'($signed(prod_p[PROD_W-1:16]))
              + TOTAL_W'($signed(prod_i[PROD_W-1:16]))
              + TOTAL_W'($signed(prod_d[PROD_W-1:16]));

        if (total > TOTAL_W'(signed'({1'b0, {(DATA_W-1){1'b1}}}))) begin
            o_pid = {1'b0, {(DATA_W-1){1'b1}}};
        end else if (total < -TOTAL_W'(signed'({1'b0, 1'b1, {(DATA_W-1){1'b0}}}))) begin
            o_pid = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            o_pid = total[DATA_W-1:0];
        end

        s_wide  = 33'(s);
        lim_pos = $signed({2'b00, i_cfg.int_limit});
        lim_neg = -lim_pos;
        priority if (s_wide > lim_pos) begin
            o_sum_next = lim_pos[DATA_W-1:0];
        end else if (s_wide < lim_neg) begin
            o_sum_next = lim_neg[DATA_W-1:0];
        end else begin
            o_sum_next = s;
        end

        o_err = err;
    end

endmodule
`default_nettype wire

/* src/three_axis_pid_quad_mixer.sv */
`default_nettype none
// Three-axis PID attitude controller feeding a quadcopter X mixer; Q16.16 data.
// A word enters an input register, passes combinational logic (three PID axes
// with nine multipliers, then the mixer and clamps) and lands in the result
// register; a new word is taken every cycle while the result side is not stalled.
// The six integrator and previous-error registers update as each word advances,
// which allows that rate. In disarmed, failsafe, error and undefined modes the
// motors read zero and the PID state is left alone. Gains and limits are to be
// written through the configuration port while the block is idle; not enforced.
module three_axis_pid_quad_mixer import tpqm_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire t_in_word           i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output t_out_word               o_out_data,
    input  wire logic               i_cfg_we,
    input  wire logic [INDEX_W-1:0] i_cfg_index,
    input  wire logic [LIMIT_W-1:0] i_cfg_data
);

    localparam int unsigned MIX_W = DATA_W + 2;

    logic [GAIN_W-1:0]  r_gain_p;
    logic [GAIN_W-1:0]  r_gain_i;
    logic [GAIN_W-1:0]  r_gain_d;
    logic [LIMIT_W-1:0] r_int_limit;
    logic [MOTOR_W-1:0] r_output_max;

    logic      r_in_valid;
    t_in_word  r_in_data;
    logic      r_out_valid;
    t_out_word r_out_data;
    t_out_word n_out_data;

    logic signed [DATA_W-1:0] r_sum [3];
    logic signed [DATA_W-1:0] r_prev [3];
    logic signed [DATA_W-1:0] n_sum [3];
    logic signed [DATA_W-1:0] n_err [3];
    logic signed [DATA_W-1:0] pid [3];
    logic signed [DATA_W-1:0] target [3];
    logic signed [DATA_W-1:0] attitude [3];

    t_pid_cfg pid_cfg;
    logic     advance;
    logic     accept;
    logic     flying;

    logic signed [MIX_W-1:0] thr;
    logic signed [MIX_W-1:0] mix_r;
    logic signed [MIX_W-1:0] mix_p;
    logic signed [MIX_W-1:0] mix_y;

    function automatic logic [MOTOR_W-1:0] clamp_motor(
        input logic signed [MIX_W-1:0] v,
        input logic [MOTOR_W-1:0]      vmax
    );
        logic [MOTOR_W-1:0] r;
        priority if (v < 0) begin
            r = '0;
        end else if (v > $signed({3'b000, vmax})) begin
            r = vmax;
        end else begin
            r = v[MOTOR_W-1:0];
        end
        return r;
    endfunction

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign accept     = i_in_valid && !o_in_stall;
    assign flying     = (r_in_data.flight_mode == MODE_ARMED) ||
                        (r_in_data.flight_mode == MODE_WARN);

    assign pid_cfg = '{gain_p: r_gain_p, gain_i: r_gain_i, gain_d: r_gain_d,
                       int_limit: r_int_limit};

    assign target[0]   = r_in_data.roll_target;
    assign target[1]   = r_in_data.pitch_target;
    assign target[2]   = r_in_data.yaw_target;
    assign attitude[0] = r_in_data.roll_attitude;
    assign attitude[1] = r_in_data.pitch_attitude;
    assign attitude[2] = r_in_data.yaw_attitude;

    for (genvar g = 0; g < 3; g++) begin : g_axis
        tpqm_pid_axis u_axis (
            .i_cfg      (pid_cfg),
            .i_target   (target[g]),
            .i_attitude (attitude[g]),
            .i_sum      (r_sum[g]),
            .i_prev     (r_prev[g]),
            .o_pid      (pid[g]),
            .o_sum_next (n_sum[g]),
            .o_err      (n_err[g])
        );
    end

    always_comb begin
        thr   = MIX_W'(r_in_data.throttle_level);
        mix_r = MIX_W'(pid[0]);
        mix_p = MIX_W'(pid[1]);
        mix_y = MIX_W'(pid[2]);
        if (flying) begin
            n_out_data.motor_front_left  = clamp_motor(thr + mix_p + mix_r - mix_y, r_output_max);
            n_out_data.motor_front_right = clamp_motor(thr + mix_p - mix_r + mix_y, r_output_max);
            n_out_data.motor_back_left   = clamp_motor(thr - mix_p + mix_r + mix_y, r_output_max);
            n_out_data.motor_back_right  = clamp_motor(thr - mix_p - mix_r - mix_y, r_output_max);
        end else begin
            n_out_data = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p     <= RESET_GAIN_P;
            r_gain_i     <= RESET_GAIN_I;
            r_gain_d     <= RESET_GAIN_D;
            r_int_limit  <= RESET_INT_LIMIT;
            r_output_max <= RESET_OUTPUT_MAX;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_GAIN_P:     r_gain_p     <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_I:     r_gain_i     <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_D:     r_gain_d     <= i_cfg_data[GAIN_W-1:0];
                CFG_INT_LIMIT:  r_int_limit  <= i_cfg_data;
                CFG_OUTPUT_MAX: r_output_max <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_sum[i]  <= '0;
                r_prev[i] <= '0;
            end
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (advance && flying) begin
                for (int i = 0; i < 3; i++) begin
                    r_sum[i]  <= n_sum[i];
                    r_prev[i] <= n_err[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_data <= i_in_data;
        end
        if (advance) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
`default_nettype wire

/* src/tpqm_checker.sv */
`default_nettype none
module tpqm_checker import tpqm_pkg::*; (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_stall,
    input wire t_in_word           i_in_data,
    input wire logic               o_out_valid,
    input wire logic               i_out_stall,
    input wire t_out_word          o_out_data
);

    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_hold_stalled : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result word changed");

    a_stall_cause : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled while result side is free");

    a_word_arrives : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) ##1 !i_out_stall |=> o_out_valid)
        else $error("accepted word did not reach the result register");

    a_grounded_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_in_data.flight_mode != MODE_ARMED &&
         i_in_data.flight_mode != MODE_WARN) ##1 !i_out_stall |=> o_out_data == '0)
        else $error("motors not zero in a grounded mode");

endmodule

bind three_axis_pid_quad_mixer tpqm_checker u_checker (.*);
`default_nettype wire

/* dv/tb.sv */
`timescale 1ns / 1ps

module tb import tpqm_pkg::*; ();

    localparam int    Q_ONE       = 65536;
    localparam longint Q_HI       = 64'sd2147483647;
    localparam longint Q_LO       = -64'sd2147483648;
    localparam int    STALL_LIMIT = 2000;
    localparam int    LONG_HOLD   = 60;
    localparam int    AXIS_ROLL   = 0;
    localparam int    AXIS_PITCH  = 1;
    localparam int    AXIS_YAW    = 2;

    localparam logic [INDEX_W-1:0] CFG_SPARE_LO = 3'd5;
    localparam logic [INDEX_W-1:0] CFG_SPARE_HI = 3'd7;
    localparam logic [GAIN_W-1:0]  GAIN_MAX     = '1;
    localparam logic [LIMIT_W-1:0] LIMIT_MAX    = '1;

    localparam logic signed [DATA_W-1:0] S_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] S_MIN = 32'sh8000_0000;

    logic               i_clk     = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    t_in_word           in_data   = '0;
    logic               out_stall = 1'b0;
    logic               cfg_we    = 1'b0;
    logic [INDEX_W-1:0] cfg_index = '0;
    logic [LIMIT_W-1:0] cfg_data  = '0;
    logic               o_in_stall;
    logic               o_out_valid;
    t_out_word          o_out_data;

    three_axis_pid_quad_mixer dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    logic [GAIN_W-1:0]         gain_p        = RESET_GAIN_P;
    logic [GAIN_W-1:0]         gain_i        = RESET_GAIN_I;
    logic [GAIN_W-1:0]         gain_d        = RESET_GAIN_D;
    logic [LIMIT_W-1:0]        sum_limit     = RESET_INT_LIMIT;
    logic [MOTOR_W-1:0]        motor_ceiling = RESET_OUTPUT_MAX;
    logic signed [DATA_W-1:0]  err_sum [3]   = '{0, 0, 0};
    logic signed [DATA_W-1:0]  last_err [3]  = '{0, 0, 0};

    t_in_word  pending_words [$];
    t_out_word expected_motors [$];
    int        fail_count     = 0;
    int        motors_checked = 0;
    int        send_gap       = 0;
    int        stall_left     = 0;
    int        idle_cycles    = 0;
    bit        long_hold_done = 1'b0;
    bit        quiet_run      = 1'b0;

    function automatic logic signed [DATA_W-1:0] clip32(input longint v);
        if (v > Q_HI) return S_MAX;
        if (v < Q_LO) return S_MIN;
        return v[DATA_W-1:0];
    endfunction

    function automatic longint axis_command(input int axis,
                                            input logic signed [DATA_W-1:0] target,
                                            input logic signed [DATA_W-1:0] attitude);
        logic signed [DATA_W-1:0] err, acc, slope;
        longint total, lim, held;
        err   = clip32(longint'(target) - longint'(attitude));
        acc   = clip32(longint'(err_sum[axis]) + longint'(err));
        slope = clip32(longint'(err) - longint'(last_err[axis]));
        total = ((longint'(gain_p) * longint'(err)) >>> 16)
              + ((longint'(gain_i) * longint'(acc)) >>> 16)
              + ((longint'(gain_d) * longint'(slope)) >>> 16);
        lim  = longint'(sum_limit);
        held = longint'(acc);
        if (held > lim) held = lim;
        if (held < -lim) held = -lim;
        err_sum[axis]  = held[DATA_W-1:0];
        last_err[axis] = err;
        return longint'(clip32(total));
    endfunction

    function automatic logic [MOTOR_W-1:0] clamp_motor(input longint v);
        if (v < 0) return '0;
        if (v > longint'(motor_ceiling)) return motor_ceiling;
        return v[MOTOR_W-1:0];
    endfunction

    function automatic t_out_word predict_motors(input t_in_word w);
        t_out_word m;
        longint    thr, roll_cmd, pitch_cmd, yaw_cmd;
        m = '0;
        if (w.flight_mode == MODE_ARMED || w.flight_mode == MODE_WARN) begin
            thr       = longint'($signed(w.throttle_level));
            roll_cmd  = axis_command(AXIS_ROLL, $signed(w.roll_target), $signed(w.roll_attitude));
            pitch_cmd = axis_command(AXIS_PITCH, $signed(w.pitch_target),
                                     $signed(w.pitch_attitude));
            yaw_cmd   = axis_command(AXIS_YAW, $signed(w.yaw_target), $signed(w.yaw_attitude));
            m.motor_front_left  = clamp_motor(thr + pitch_cmd + roll_cmd - yaw_cmd);
            m.motor_front_right = clamp_motor(thr + pitch_cmd - roll_cmd + yaw_cmd);
            m.motor_back_left   = clamp_motor(thr - pitch_cmd + roll_cmd + yaw_cmd);
            m.motor_back_right  = clamp_motor(thr - pitch_cmd - roll_cmd - yaw_cmd);
        end
        return m;
    endfunction

    function automatic logic signed [DATA_W-1:0] random_q16();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0: return S_MAX;
                    1: return S_MIN;
                    2: return '0;
                    default: return -1;
                endcase
            end
            1, 2: return $urandom();
            3, 4: return int'($urandom_range(0, 32'h1FFF_FFFF)) - 32'sh1000_0000;
            default: return int'($urandom_range(0, 32'h007F_FFFF)) - 32'sh0040_0000;
        endcase
    endfunction

    task automatic queue_word(input logic [MODE_W-1:0] mode,
                              input logic signed [DATA_W-1:0] roll_t, pitch_t, yaw_t, thr,
                              input logic signed [DATA_W-1:0] roll_a, pitch_a, yaw_a);
        t_in_word w;
        w.flight_mode    = mode;
        w.roll_target    = roll_t;
        w.pitch_target   = pitch_t;
        w.yaw_target     = yaw_t;
        w.throttle_level = thr;
        w.roll_attitude  = roll_a;
        w.pitch_attitude = pitch_a;
        w.yaw_attitude   = yaw_a;
        pending_words.push_back(w);
    endtask

    task automatic queue_random(input int count);
        logic [MODE_W-1:0]        mode;
        logic signed [DATA_W-1:0] thr;
        repeat (count) begin
            if ($urandom_range(0, 4) != 0)
                mode = MODE_W'($urandom_range(MODE_ARMED, MODE_WARN));
            else
                mode = MODE_W'($urandom_range(0, (1 << MODE_W) - 1));
            if ($urandom_range(0, 9) < 7)
                thr = $urandom_range(0, 131072000);
            else
                thr = random_q16();
            queue_word(mode, random_q16(), random_q16(), random_q16(), thr,
                       random_q16(), random_q16(), random_q16());
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        while (pending_words.size() != 0 || in_valid || expected_motors.size() != 0)
            @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [LIMIT_W-1:0] value);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            CFG_GAIN_P:     gain_p        = value[GAIN_W-1:0];
            CFG_GAIN_I:     gain_i        = value[GAIN_W-1:0];
            CFG_GAIN_D:     gain_d        = value[GAIN_W-1:0];
            CFG_INT_LIMIT:  sum_limit     = value;
            CFG_OUTPUT_MAX: motor_ceiling = value;
            default: ;
        endcase
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_gains(input logic [GAIN_W-1:0] p, i, d,
                             input logic [LIMIT_W-1:0] lim, ceiling);
        write_reg(CFG_GAIN_P, LIMIT_W'(p));
        write_reg(CFG_GAIN_I, LIMIT_W'(i));
        write_reg(CFG_GAIN_D, LIMIT_W'(d));
        write_reg(CFG_INT_LIMIT, lim);
        write_reg(CFG_OUTPUT_MAX, ceiling);
    endtask

    task automatic compare_field(input string name, input logic [MOTOR_W-1:0] want, got);
        if (want !== got) begin
            $error("%s expected %0d got %0d", name, want, got);
            fail_count++;
        end
    endtask

    task automatic check_motors(input t_out_word got);
        t_out_word want;
        if (expected_motors.size() == 0) begin
            $error("motor word with nothing expected: %h", got);
            fail_count++;
        end else begin
            want = expected_motors.pop_front();
            compare_field("motor_front_left", want.motor_front_left, got.motor_front_left);
            compare_field("motor_front_right", want.motor_front_right, got.motor_front_right);
            compare_field("motor_back_left", want.motor_back_left, got.motor_back_left);
            compare_field("motor_back_right", want.motor_back_right, got.motor_back_right);
        end
        motors_checked++;
    endtask

    always @(posedge i_clk) begin : sender
        logic take;
        take = in_valid && !o_in_stall;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (take) begin
                expected_motors.push_back(predict_motors(in_data));
            end
            if (!in_valid || take) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end else if (pending_words.size() != 0) begin
                    if (!quiet_run && $urandom_range(0, 5) == 0) begin
                        send_gap = $urandom_range(0, 3);
                        in_valid <= 1'b0;
                    end else begin
                        in_data  <= pending_words.pop_front();
                        in_valid <= 1'b1;
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !out_stall) begin
                check_motors(o_out_data);
            end
            // hold off long enough to back the block up into its input
            if (!long_hold_done && motors_checked == 100) begin
                long_hold_done = 1'b1;
                stall_left = LONG_HOLD;
            end else if (stall_left == 0 && !quiet_run && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(1, 4);
            end
            if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!rst_n || (in_valid && !o_in_stall) || (o_out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("FAIL three_axis_pid_quad_mixer");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        rst_n <= 1'b1;

        queue_word(MODE_ARMED, 0, 0, 0, 0, 0, 0, 0);
        queue_word(MODE_ARMED, 0, 0, 0, 1000 * Q_ONE, 0, 0, 0);
        queue_word(MODE_ARMED, 10 * Q_ONE, 0, 0, 1000 * Q_ONE, 0, 0, 0);
        queue_word(MODE_WARN, 0, -5 * Q_ONE, 0, 1000 * Q_ONE, 0, 0, 3 * Q_ONE);
        queue_word(MODE_DISARMED, S_MAX, S_MIN, S_MAX, S_MAX, S_MIN, S_MAX, S_MIN);
        queue_word(MODE_FAILSAFE, S_MAX, S_MAX, S_MAX, S_MAX, S_MIN, S_MIN, S_MIN);
        queue_word(MODE_ERROR, -1, -1, -1, -1, 0, 0, 0);
        queue_word(MODE_W'(MODE_ERROR + 1), S_MAX, S_MAX, S_MAX, S_MAX, S_MIN, S_MIN, S_MIN);
        queue_word(MODE_W'(MODE_ERROR + 2), 7 * Q_ONE, 7 * Q_ONE, 7 * Q_ONE, 900 * Q_ONE,
                   0, 0, 0);
        queue_word(MODE_W'(MODE_ERROR + 3), -1, -1, -1, -1, -1, -1, -1);
        queue_word(MODE_ARMED, S_MAX, S_MAX, S_MAX, 1000 * Q_ONE, S_MIN, S_MIN, S_MIN);
        queue_word(MODE_ARMED, S_MIN, S_MIN, S_MIN, 1000 * Q_ONE, S_MAX, S_MAX, S_MAX);
        queue_word(MODE_ARMED, 0, 0, 0, S_MAX, 0, 0, 0);
        queue_word(MODE_ARMED, 0, 0, 0, S_MIN, 0, 0, 0);
        queue_word(MODE_ARMED, -200 * Q_ONE, 0, 0, 0, 0, 0, 0);
        repeat (4) queue_word(MODE_ARMED, 50 * Q_ONE, 0, 0, 1000 * Q_ONE, 0, 0, 0);
        queue_word(MODE_WARN, 0, 0, S_MAX, 1000 * Q_ONE, 0, 0, -1000 * Q_ONE);
        queue_word(MODE_ARMED, -1, -1, -1, -1, -1, -1, -1);
        queue_word(MODE_ARMED, S_MAX, S_MAX, S_MAX, 500 * Q_ONE, S_MAX, S_MAX, S_MAX);
        queue_word(MODE_WARN, S_MIN, S_MIN, S_MIN, S_MIN, 0, 0, 0);
        queue_random(250);
        drain();

        set_gains(GAIN_MAX, '0, GAIN_MAX, '0, LIMIT_MAX);
        write_reg(CFG_SPARE_LO, '0);
        write_reg(CFG_SPARE_HI, LIMIT_MAX);
        queue_random(150);
        drain();

        set_gains('0, GAIN_MAX, '0, LIMIT_MAX, '0);
        queue_random(40);
        drain();

        set_gains(GAIN_W'($urandom_range(0, 24'h03_FFFF)),
                  GAIN_W'($urandom_range(0, 24'h03_FFFF)),
                  GAIN_W'($urandom_range(0, 24'h03_FFFF)),
                  LIMIT_W'($urandom_range(0, 31'h0FFF_FFFF)),
                  LIMIT_W'($urandom_range(31'h0100_0000, LIMIT_MAX)));
        queue_random(200);
        drain();

        quiet_run = 1'b1;
        set_gains(GAIN_W'(2 * Q_ONE), GAIN_W'(Q_ONE / 10), GAIN_W'(Q_ONE / 2),
                  LIMIT_W'(500 * Q_ONE), LIMIT_W'(1500 * Q_ONE));
        queue_random(240);
        drain();

        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && expected_motors.size() == 0)
            $display("PASS three_axis_pid_quad_mixer");
        else
            $display("FAIL three_axis_pid_quad_mixer");
        $finish;
    end

endmodule

/* filelist.f */
src/tpqm_pkg.sv
src/tpqm_pid_axis.sv
src/three_axis_pid_quad_mixer.sv
src/tpqm_checker.sv
dv/tb.sv
